### hdl/sdot_pkg.sv
package sdot_pkg;

    localparam int REQ_BITS    = 2;
    localparam int DIR_BITS    = 2;
    localparam int STATUS_BITS = 3;

    localparam logic [DIR_BITS-1:0] DIR_DOWN   = 2'b01;
    localparam int                  DIR_UP_BIT = 1;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_MOVE   = 2'd2
    } t_req;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_PLACED    = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

endpackage

### hdl/sdot_ram.sv
module sdot_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 26
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### hdl/sdot_seq.sv
module sdot_seq
    import sdot_pkg::*;
#(
    parameter  int TABLE_DEPTH = 32,
    parameter  int KEY_BITS    = 16,
    parameter  int ID_BITS     = 10,
    localparam int POS_BITS    = $clog2(TABLE_DEPTH),
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1),
    localparam int ENTRY_W     = ID_BITS + KEY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [REQ_BITS-1:0]        i_kind,
    input  logic [ID_BITS-1:0]         i_id,
    input  logic signed [KEY_BITS-1:0] i_key,
    input  logic [POS_BITS-1:0]        i_start,
    input  logic [DIR_BITS-1:0]        i_dir,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ID_BITS-1:0]         o_id,
    output logic [POS_BITS-1:0]        o_pos,
    output t_status                    o_status,
    output logic                       o_last,
    output logic                       o_rd_en,
    output logic [POS_BITS-1:0]        o_rd_addr,
    input  logic [ENTRY_W-1:0]         i_rd_data,
    output logic                       o_wr_en,
    output logic [POS_BITS-1:0]        o_wr_addr,
    output logic [ENTRY_W-1:0]         o_wr_data
);

    localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_FIND,
        S_MV_FIND,
        S_SHIFT_UP,
        S_RM_FIND,
        S_SHIFT_DN,
        S_FINAL
    } t_state;

    t_state                      r_state, n_state;
    logic [COUNT_BITS-1:0]       r_count, n_count;
    logic [COUNT_BITS-1:0]       r_k, n_k;
    logic [COUNT_BITS-1:0]       r_end, n_end;
    logic [POS_BITS-1:0]         r_pos, n_pos;
    logic [ENTRY_W-1:0]          r_carry, n_carry;
    logic [ID_BITS-1:0]          r_id, n_id;
    logic signed [KEY_BITS-1:0]  r_key, n_key;
    t_req                        r_kind, n_kind;
    t_status                     r_status, n_status;
    logic                        r_force, n_force;
    logic                        r_ovalid, n_ovalid;
    logic [ID_BITS-1:0]          r_oid, n_oid;
    logic [POS_BITS-1:0]         r_opos, n_opos;
    t_status                     r_ostat, n_ostat;
    logic                        r_olast, n_olast;

    logic                        slot_free;
    logic [ID_BITS-1:0]          rd_id;
    logic signed [KEY_BITS-1:0]  rd_key;
    logic [ENTRY_W-1:0]          new_entry;
    logic [COUNT_BITS-1:0]       kp1, km1, km2, start_ext, sp1, sm1;

    assign slot_free = !r_ovalid || i_ready;
    assign rd_id     = i_rd_data[ID_BITS-1:0];
    assign rd_key    = $signed(i_rd_data[ENTRY_W-1:ID_BITS]);
    assign new_entry = {r_key, r_id};
    assign kp1       = r_k + 1'b1;
    assign km1       = r_k - 1'b1;
    assign km2       = r_k - 2'd2;
    assign start_ext = COUNT_BITS'(i_start);
    assign sp1       = start_ext + 1'b1;
    assign sm1       = start_ext - 1'b1;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_id     = r_oid;
    assign o_pos    = r_opos;
    assign o_status = r_ostat;
    assign o_last   = r_olast;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_end     = r_end;
        n_pos     = r_pos;
        n_carry   = r_carry;
        n_id      = r_id;
        n_key     = r_key;
        n_kind    = r_kind;
        n_status  = r_status;
        n_force   = r_force;
        n_ovalid  = r_ovalid && !i_ready;
        n_oid     = r_oid;
        n_opos    = r_opos;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        o_rd_en   = 1'b0;
        o_rd_addr = kp1[POS_BITS-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_k[POS_BITS-1:0];
        o_wr_data = new_entry;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_id     = i_id;
                    n_key    = i_key;
                    n_kind   = t_req'(i_kind);
                    n_force  = 1'b0;
                    n_pos    = '0;
                    n_status = ST_PLACED;
                    case (t_req'(i_kind))
                        REQ_INSERT: begin
                            if (r_count == DEPTH_C) begin
                                n_status = ST_FULL;
                                n_state  = S_FINAL;
                            end else begin
                                n_k       = '0;
                                n_end     = r_count;
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = S_INS_FIND;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FINAL;
                            end else begin
                                n_k       = '0;
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = S_RM_FIND;
                            end
                        end
                        REQ_MOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FINAL;
                            end else if (start_ext >= r_count) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_FINAL;
                            end else if (i_dir[DIR_UP_BIT]) begin
                                n_k       = start_ext;
                                n_end     = start_ext;
                                o_rd_en   = (start_ext != '0);
                                o_rd_addr = sm1[POS_BITS-1:0];
                                n_state   = S_MV_FIND;
                            end else if (i_dir == DIR_DOWN) begin
                                n_k       = sp1;
                                o_rd_en   = (sp1 < r_count);
                                o_rd_addr = sp1[POS_BITS-1:0];
                                n_state   = S_SHIFT_DN;
                            end else begin
                                n_k     = start_ext;
                                n_end   = start_ext;
                                n_state = S_INS_FIND;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_FIND: begin
                if ((r_k == r_end) || r_force || !(r_key > rd_key)) begin
                    o_wr_en = 1'b1;
                    n_pos   = r_k[POS_BITS-1:0];
                    if (r_k == r_end) begin
                        n_state = S_FINAL;
                    end else begin
                        n_carry = i_rd_data;
                        n_k     = kp1;
                        o_rd_en = (kp1 < r_end);
                        n_state = S_SHIFT_UP;
                    end
                end else begin
                    n_k     = kp1;
                    o_rd_en = (kp1 < r_end);
                end
            end
            S_MV_FIND: begin
                if ((r_k == '0) || !(r_key < rd_key)) begin
                    n_force   = 1'b1;
                    o_rd_en   = (r_k != r_end);
                    o_rd_addr = r_k[POS_BITS-1:0];
                    n_state   = S_INS_FIND;
                end else begin
                    n_k       = km1;
                    o_rd_en   = (km1 != '0);
                    o_rd_addr = km2[POS_BITS-1:0];
                end
            end
            S_SHIFT_UP: begin
                if (slot_free) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = r_carry;
                    n_ovalid  = 1'b1;
                    n_oid     = r_carry[ID_BITS-1:0];
                    n_opos    = r_k[POS_BITS-1:0];
                    n_ostat   = ST_PLACED;
                    n_olast   = 1'b0;
                    if (r_k == r_end) begin
                        n_state = S_FINAL;
                    end else begin
                        n_carry = i_rd_data;
                        n_k     = kp1;
                        o_rd_en = (kp1 < r_end);
                    end
                end
            end
            S_RM_FIND: begin
                if (r_k == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FINAL;
                end else if (rd_id == r_id) begin
                    n_pos    = r_k[POS_BITS-1:0];
                    n_status = ST_REMOVED;
                    n_k      = kp1;
                    o_rd_en  = (kp1 < r_count);
                    n_state  = S_SHIFT_DN;
                end else begin
                    n_k     = kp1;
                    o_rd_en = (kp1 < r_count);
                end
            end
            S_SHIFT_DN: begin
                if ((r_k == r_count) || ((r_kind == REQ_MOVE) && !(r_key > rd_key))) begin
                    if (r_kind == REQ_MOVE) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = km1[POS_BITS-1:0];
                        n_pos     = km1[POS_BITS-1:0];
                    end
                    n_state = S_FINAL;
                end else if (slot_free) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = km1[POS_BITS-1:0];
                    o_wr_data = i_rd_data;
                    n_ovalid  = 1'b1;
                    n_oid     = rd_id;
                    n_opos    = km1[POS_BITS-1:0];
                    n_ostat   = ST_PLACED;
                    n_olast   = 1'b0;
                    n_k       = kp1;
                    o_rd_en   = (kp1 < r_count);
                end
            end
            S_FINAL: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oid    = r_id;
                    n_opos   = r_pos;
                    n_ostat  = r_status;
                    n_olast  = 1'b1;
                    if ((r_kind == REQ_INSERT) && (r_status == ST_PLACED)) begin
                        n_count = r_count + 1'b1;
                    end else if (r_status == ST_REMOVED) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_k      <= n_k;
        r_end    <= n_end;
        r_pos    <= n_pos;
        r_carry  <= n_carry;
        r_id     <= n_id;
        r_key    <= n_key;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_force  <= n_force;
        r_oid    <= n_oid;
        r_opos   <= n_opos;
        r_ostat  <= n_ostat;
        r_olast  <= n_olast;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rd_en && o_wr_en && (o_rd_addr == o_wr_addr)))
        else $error("read and write to the same entry in one cycle");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && slot_free && r_kind == REQ_INSERT && r_status == ST_PLACED)
        |=> (r_count == COUNT_BITS'($past(r_count) + 1'b1)))
        else $error("insert did not grow the table");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && slot_free) |=> (r_state == S_IDLE && r_ovalid && r_olast))
        else $error("closing item not marked last");
`endif

endmodule

### hdl/sorted_depth_order_table_unit.sv
// Sorted depth-order table: entity ids kept in ascending order of a signed key.
// Slave stream carries one request per item; tuser is the request kind
// (insert, remove by id, move after key change). Master stream carries one
// item per entry whose position was set or changed, shifted entries first in
// ascending position order, then the entry the request placed or removed;
// tlast marks the final item of a request and tuser holds its status.
// A request walks the table (one read port, one write port) one entry per
// cycle through a read-ahead pipeline while the receiver keeps up; a move up
// walks toward position zero to its new place and then back. The next request
// is taken the cycle after the closing item of the last one is loaded into the
// output register, never while a request is still in progress.
// Reset clears the entry count, the state and the output valid flag only;
// table contents need no clearing pass.
// When the receiver stalls, the walk holds with the pending item in the
// output register and resumes when it is taken.
module sorted_depth_order_table_unit
    import sdot_pkg::*;
#(
    parameter  int TABLE_DEPTH = 32,
    parameter  int KEY_BITS    = 16,
    parameter  int ID_BITS     = 10,
    localparam int POS_BITS    = $clog2(TABLE_DEPTH),
    localparam int IN_W        = ID_BITS + KEY_BITS + POS_BITS + DIR_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = ID_BITS + POS_BITS,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entity_id, sort_key, start_position, move_direction
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [REQ_BITS-1:0]    s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // moved_id, new_position
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_BITS-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int ENTRY_W = ID_BITS + KEY_BITS;
    localparam int KEY_LO  = ID_BITS;
    localparam int POS_LO  = KEY_LO + KEY_BITS;
    localparam int DIR_LO  = POS_LO + POS_BITS;

    logic [ID_BITS-1:0]         in_id;
    logic signed [KEY_BITS-1:0] in_key;
    logic [POS_BITS-1:0]        in_start;
    logic [DIR_BITS-1:0]        in_dir;
    logic [ID_BITS-1:0]         out_id;
    logic [POS_BITS-1:0]        out_pos;
    t_status                    out_status;
    logic                       rd_en, wr_en;
    logic [POS_BITS-1:0]        rd_addr, wr_addr;
    logic [ENTRY_W-1:0]         rd_data, wr_data;

    assign in_id    = s_axis_tdata[ID_BITS-1:0];
    assign in_key   = $signed(s_axis_tdata[POS_LO-1:KEY_LO]);
    assign in_start = s_axis_tdata[DIR_LO-1:POS_LO];
    assign in_dir   = s_axis_tdata[IN_W-1:DIR_LO];

    assign m_axis_tdata = OUT_TDATA_W'({out_pos, out_id});
    assign m_axis_tuser = out_status;

    sdot_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .ID_BITS     (ID_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_id      (in_id),
        .i_key     (in_key),
        .i_start   (in_start),
        .i_dir     (in_dir),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_id      (out_id),
        .o_pos     (out_pos),
        .o_status  (out_status),
        .o_last    (m_axis_tlast),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    sdot_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (POS_BITS),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

### tb/sorted_depth_order_table_unit_tb.sv
`timescale 1ns / 1ps

module sorted_depth_order_table_unit_tb;
    import sdot_pkg::*;

    localparam int DEPTH          = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 16;
    localparam int RANDOM_ITEMS   = 136;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 10;

    localparam logic [REQ_BITS-1:0] REQ_IGNORED = 2'd3;
    localparam logic [DIR_BITS-1:0] DIR_NONE    = 2'b00;
    localparam logic [DIR_BITS-1:0] DIR_UP      = 2'b11;
    localparam logic [DIR_BITS-1:0] DIR_UP_ALT  = 2'b10;

    localparam int ROW_PLAN = 0;
    localparam int ROW_LIVE = 1;

    typedef struct packed {
        logic [REQ_BITS-1:0] kind;
        logic [9:0]          id;
        logic [15:0]         key;
        logic [4:0]          start;
        logic [DIR_BITS-1:0] dir;
    } t_depth_req;

    typedef struct packed {
        logic [9:0] id;
        logic [4:0] pos;
        t_status    st;
        logic       last;
    } t_placed;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // entity_id, sort_key, start_position, move_direction
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // req_type
    logic [REQ_BITS-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // moved_id, new_position
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status
    logic [STATUS_BITS-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    logic [9:0]         tbl_id  [2][DEPTH];
    logic signed [15:0] tbl_key [2][DEPTH];
    int                 tbl_cnt [2];

    t_depth_req request_q[$];
    t_placed    expected_moves[$];
    t_depth_req on_bus;
    int         requests_total = 0;
    int         requests_taken = 0;
    int         errors = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         idle_cycles = 0;
    int         stall_age = 0;
    logic [15:0] stall_pat = 16'hFFFF;

    sorted_depth_order_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_placed mk_placed(input logic [9:0] id, input int pos, input t_status st);
        t_placed p;
        p.id   = id;
        p.pos  = pos[4:0];
        p.st   = st;
        p.last = 1'b0;
        return p;
    endfunction

    task automatic apply_request(input int row, input t_depth_req r);
        t_placed moves[$];
        int      cnt;
        int      i;
        int      j;
        int      k;
        cnt = tbl_cnt[row];
        case (r.kind)
            REQ_INSERT: begin
                if (cnt >= DEPTH) begin
                    moves.insert(moves.size(), mk_placed(r.id, 0, ST_FULL));
                end else begin
                    i = 0;
                    while (i < cnt && $signed(r.key) > tbl_key[row][i])
                        i++;
                    for (k = cnt; k > i; k--) begin
                        tbl_id[row][k]  = tbl_id[row][k-1];
                        tbl_key[row][k] = tbl_key[row][k-1];
                    end
                    cnt++;
                    for (k = i + 1; k < cnt; k++)
                        moves.insert(moves.size(), mk_placed(tbl_id[row][k], k, ST_PLACED));
                    tbl_id[row][i]  = r.id;
                    tbl_key[row][i] = r.key;
                    moves.insert(moves.size(), mk_placed(r.id, i, ST_PLACED));
                end
            end
            REQ_REMOVE: begin
                if (cnt == 0) begin
                    moves.insert(moves.size(), mk_placed(r.id, 0, ST_EMPTY));
                end else begin
                    i = 0;
                    while (i < cnt && tbl_id[row][i] != r.id)
                        i++;
                    if (i >= cnt) begin
                        moves.insert(moves.size(), mk_placed(r.id, 0, ST_NOT_FOUND));
                    end else begin
                        for (k = i; k + 1 < cnt; k++) begin
                            tbl_id[row][k]  = tbl_id[row][k+1];
                            tbl_key[row][k] = tbl_key[row][k+1];
                            moves.insert(moves.size(),
                                         mk_placed(tbl_id[row][k], k, ST_PLACED));
                        end
                        cnt--;
                        moves.insert(moves.size(), mk_placed(r.id, i, ST_REMOVED));
                    end
                end
            end
            REQ_MOVE: begin
                if (cnt == 0) begin
                    moves.insert(moves.size(), mk_placed(r.id, 0, ST_EMPTY));
                end else if (int'(r.start) >= cnt) begin
                    moves.insert(moves.size(), mk_placed(r.id, 0, ST_NOT_FOUND));
                end else begin
                    j = r.start;
                    if (r.dir[DIR_UP_BIT]) begin
                        while (j > 0 && $signed(r.key) < tbl_key[row][j-1])
                            j--;
                        for (k = r.start; k > j; k--) begin
                            tbl_id[row][k]  = tbl_id[row][k-1];
                            tbl_key[row][k] = tbl_key[row][k-1];
                        end
                        for (k = j + 1; k <= r.start; k++)
                            moves.insert(moves.size(),
                                         mk_placed(tbl_id[row][k], k, ST_PLACED));
                    end else if (r.dir == DIR_DOWN) begin
                        while (j + 1 < cnt && $signed(r.key) > tbl_key[row][j+1])
                            j++;
                        for (k = r.start; k < j; k++) begin
                            tbl_id[row][k]  = tbl_id[row][k+1];
                            tbl_key[row][k] = tbl_key[row][k+1];
                            moves.insert(moves.size(),
                                         mk_placed(tbl_id[row][k], k, ST_PLACED));
                        end
                    end
                    tbl_id[row][j]  = r.id;
                    tbl_key[row][j] = r.key;
                    moves.insert(moves.size(), mk_placed(r.id, j, ST_PLACED));
                end
            end
            default: begin
            end
        endcase
        if (moves.size() > 0)
            moves[moves.size()-1].last = 1'b1;
        tbl_cnt[row] = cnt;
        if (row == ROW_LIVE)
            foreach (moves[n])
                expected_moves.insert(expected_moves.size(), moves[n]);
    endtask

    task automatic queue_request(input logic [REQ_BITS-1:0] kind, input logic [9:0] id,
                                 input logic [15:0] key, input logic [4:0] start,
                                 input logic [DIR_BITS-1:0] dir);
        t_depth_req r;
        r.kind  = kind;
        r.id    = id;
        r.key   = key;
        r.start = start;
        r.dir   = dir;
        request_q.insert(request_q.size(), r);
        apply_request(ROW_PLAN, r);
    endtask

    function automatic logic [15:0] draft_key();
        int          cnt;
        int          sel;
        logic [15:0] k;
        cnt = tbl_cnt[ROW_PLAN];
        sel = $urandom_range(0, 9);
        k = 16'($urandom);
        if (sel == 0)
            k = 16'h8000;
        else if (sel == 1)
            k = 16'h7FFF;
        else if (sel <= 3 && cnt > 0)
            k = tbl_key[ROW_PLAN][$urandom_range(0, cnt - 1)];
        else if (sel <= 5 && cnt > 0)
            k = 16'(tbl_key[ROW_PLAN][$urandom_range(0, cnt - 1)] +
                    $urandom_range(0, 6) - 3);
        return k;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(ROW_LIVE, on_bus);
                requests_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    on_bus = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, on_bus.dir, on_bus.start, on_bus.key, on_bus.id};
                    s_axis_tuser  <= on_bus.kind;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(0, 6);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_age == 63) begin
            stall_age     <= 0;
            stall_pat     <= ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                             (16'($urandom) | 16'h0001);
            m_axis_tready <= 1'b1;
        end else begin
            stall_age     <= stall_age + 1;
            stall_pat     <= {stall_pat[0], stall_pat[15:1]};
            m_axis_tready <= stall_pat[0];
        end
    end

    task automatic flag_error(input string text);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s", $time, text);
    endtask

    always @(posedge i_clk) begin
        t_placed want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_moves.size() == 0) begin
                flag_error($sformatf("unexpected item id %0d pos %0d status %0d last %0d",
                                     m_axis_tdata[9:0], m_axis_tdata[14:10],
                                     m_axis_tuser, m_axis_tlast));
            end else begin
                want = expected_moves.pop_front();
                if (m_axis_tdata[9:0] !== want.id || m_axis_tdata[14:10] !== want.pos ||
                    m_axis_tuser !== want.st || m_axis_tlast !== want.last)
                    flag_error($sformatf({"mismatch: got id %0d pos %0d status %0d last %0d,",
                                          " expected id %0d pos %0d status %0d last %0d"},
                                         m_axis_tdata[9:0], m_axis_tdata[14:10],
                                         m_axis_tuser, m_axis_tlast,
                                         want.id, want.pos, want.st, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int          n_items;
        int          roll;
        int          cnt;
        int          pos;
        bit          grow;
        bit          saw_full;
        bit          saw_empty;
        logic [15:0] key;
        logic [9:0]  id;
        logic [1:0]  dir;

        tbl_cnt[ROW_PLAN] = 0;
        tbl_cnt[ROW_LIVE] = 0;

        queue_request(REQ_REMOVE, 10'h3FF, 16'h0000, 5'd0, DIR_NONE);
        queue_request(REQ_MOVE, 10'h000, 16'h1234, 5'd0, DIR_DOWN);
        queue_request(REQ_IGNORED, 10'h3FF, 16'hFFFF, 5'd31, DIR_UP);
        queue_request(REQ_INSERT, 10'd0, 16'h8000, 5'd0, DIR_NONE);
        queue_request(REQ_INSERT, 10'd1023, 16'h7FFF, 5'd31, DIR_UP);
        queue_request(REQ_INSERT, 10'd5, 16'h0000, 5'd0, DIR_NONE);
        queue_request(REQ_INSERT, 10'd6, 16'h0000, 5'd0, DIR_NONE);
        queue_request(REQ_INSERT, 10'd7, 16'h8000, 5'd0, DIR_NONE);
        queue_request(REQ_INSERT, 10'd8, 16'd100, 5'd0, DIR_NONE);
        queue_request(REQ_REMOVE, 10'd999, 16'h0000, 5'd0, DIR_NONE);
        queue_request(REQ_MOVE, 10'd1, 16'h0000, 5'd31, DIR_DOWN);
        queue_request(REQ_MOVE, 10'd5, 16'h0000, 5'd2, DIR_NONE);
        queue_request(REQ_MOVE, 10'd1023, 16'h8000, 5'd5, DIR_UP_ALT);
        queue_request(REQ_MOVE, tbl_id[ROW_PLAN][0], 16'h7FFF, 5'd0, DIR_DOWN);
        queue_request(REQ_MOVE, tbl_id[ROW_PLAN][3], -16'sd100, 5'd3, DIR_UP);
        queue_request(REQ_MOVE, tbl_id[ROW_PLAN][1], 16'h8000, 5'd1, DIR_DOWN);
        queue_request(REQ_MOVE, tbl_id[ROW_PLAN][4], 16'h7FFF, 5'd4, DIR_UP);
        queue_request(REQ_REMOVE, tbl_id[ROW_PLAN][tbl_cnt[ROW_PLAN]-1], 16'h0000, 5'd0,
                      DIR_NONE);
        queue_request(REQ_REMOVE, tbl_id[ROW_PLAN][0], 16'h0000, 5'd0, DIR_NONE);
        queue_request(REQ_REMOVE, tbl_id[ROW_PLAN][1], 16'h0000, 5'd0, DIR_NONE);

        grow      = 1'b1;
        saw_full  = 1'b0;
        saw_empty = 1'b0;
        n_items   = 0;
        while (n_items < RANDOM_ITEMS) begin
            cnt = tbl_cnt[ROW_PLAN];
            if (grow && cnt == DEPTH && saw_full && $urandom_range(0, 2) == 0) begin
                grow     = 1'b0;
                saw_full = 1'b0;
            end else if (!grow && cnt == 0 && saw_empty && $urandom_range(0, 2) == 0) begin
                grow      = 1'b1;
                saw_empty = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                queue_request(REQ_IGNORED, 10'($urandom), 16'($urandom), 5'($urandom),
                              DIR_BITS'($urandom));
            end else begin
                n_items++;
                if (roll < (grow ? 73 : 13)) begin
                    if (cnt == DEPTH)
                        saw_full = 1'b1;
                    queue_request(REQ_INSERT, 10'($urandom), draft_key(), 5'($urandom),
                                  DIR_BITS'($urandom));
                end else if (roll < (grow ? 83 : 83)) begin
                    if (cnt == 0)
                        saw_empty = 1'b1;
                    id = (cnt > 0 && $urandom_range(0, 4) != 0) ?
                         tbl_id[ROW_PLAN][$urandom_range(0, cnt - 1)] : 10'($urandom);
                    queue_request(REQ_REMOVE, id, 16'($urandom), 5'($urandom),
                                  DIR_BITS'($urandom));
                end else if (cnt > 0 && $urandom_range(0, 6) != 0) begin
                    pos = $urandom_range(0, cnt - 1);
                    key = draft_key();
                    if ($signed(key) > tbl_key[ROW_PLAN][pos])
                        dir = DIR_DOWN;
                    else if ($signed(key) < tbl_key[ROW_PLAN][pos])
                        dir = $urandom_range(0, 1) ? DIR_UP : DIR_UP_ALT;
                    else
                        dir = DIR_NONE;
                    if ($urandom_range(0, 9) == 0)
                        dir = 2'($urandom);
                    id = ($urandom_range(0, 9) == 0) ? 10'($urandom) : tbl_id[ROW_PLAN][pos];
                    queue_request(REQ_MOVE, id, key, 5'(pos), dir);
                end else begin
                    if (cnt == 0)
                        saw_empty = 1'b1;
                    queue_request(REQ_MOVE, 10'($urandom), 16'($urandom), 5'($urandom),
                                  DIR_BITS'($urandom));
                end
            end
        end
        requests_total = request_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < requests_total || expected_moves.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        errors += expected_moves.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hdl/sdot_pkg.sv
hdl/sdot_ram.sv
hdl/sdot_seq.sv
hdl/sorted_depth_order_table_unit.sv
tb/sorted_depth_order_table_unit_tb.sv
